FILE: sv/dccpm_pkg.sv
// ----------------------------------------------------------------------------
// dccpm_pkg
// shared types and constants of the dual channel clip and peak meter
// ----------------------------------------------------------------------------
package dccpm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int COUNT_W  = 17;
    localparam int UP_W     = 11;
    localparam int DOWN_W   = 12;
    localparam int RESULT_W = 4 * COUNT_W + 2 * UP_W + 2 * DOWN_W;
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic signed [SAMPLE_W-1:0] CLIP_HIGH = 12'sd2047;
    localparam logic signed [SAMPLE_W-1:0] CLIP_LOW  = -12'sd2048;
    localparam logic [COUNT_W-1:0]         WINDOW_RESET = 17'd1000;
    localparam logic [COUNT_W-1:0]         COUNT_MAX17  = 17'h1FFFF;

    typedef struct packed {
        logic [COUNT_W-1:0] clip_high;
        logic [COUNT_W-1:0] clip_low;
        logic [UP_W-1:0]    peak_up;
        logic [DOWN_W-1:0]  peak_down;
    } chan_stats_t;

endpackage

FILE: sv/dccpm_chan_acc.sv
// ----------------------------------------------------------------------------
// dccpm_chan_acc
// per-channel clip counters and peak trackers for the running block
// ----------------------------------------------------------------------------
module dccpm_chan_acc
    import dccpm_pkg::*;
#(
    parameter logic [COUNT_W-1:0] COUNT_LIMIT = 17'd65536
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       take,
    input  logic                       last,
    input  logic                       track,
    input  logic signed [SAMPLE_W-1:0] sample,
    output chan_stats_t                stats_next
);

    chan_stats_t stats_reg;
    logic [DOWN_W-1:0] mag;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c < COUNT_LIMIT) ? c + 1'b1 : COUNT_LIMIT;
    endfunction

    assign mag = DOWN_W'(~sample) + 1'b1;

    always_comb begin
        stats_next = stats_reg;
        if (sample == CLIP_HIGH) begin
            stats_next.clip_high = sat_inc(stats_reg.clip_high);
        end else if (sample == CLIP_LOW) begin
            stats_next.clip_low = sat_inc(stats_reg.clip_low);
        end
        if (track) begin
            if (!sample[SAMPLE_W-1] && (sample[UP_W-1:0] > stats_reg.peak_up)) begin
                stats_next.peak_up = sample[UP_W-1:0];
            end
            if (sample[SAMPLE_W-1] && (mag > stats_reg.peak_down)) begin
                stats_next.peak_down = mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stats_reg <= '0;
        end else if (take) begin
            stats_reg <= last ? '0 : stats_next;
        end
    end

endmodule

FILE: sv/dccpm_out_buf.sv
// ----------------------------------------------------------------------------
// dccpm_out_buf
// result register with one skid entry toward the master side
// ----------------------------------------------------------------------------
module dccpm_out_buf
    import dccpm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [M_DATA_W-1:0] in_data,
    output logic                in_ready,
    output logic                out_valid,
    output logic [M_DATA_W-1:0] out_data,
    input  logic                out_ready
);

    logic                out_valid_reg;
    logic                skid_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] skid_data_reg;
    logic                pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else if (in_valid) begin
                out_data_reg <= in_data;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg) begin
                out_data_reg  <= in_data;
                out_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule

FILE: sv/dual_channel_clip_peak_meter_unit.sv
// ----------------------------------------------------------------------------
// dual_channel_clip_peak_meter_unit
// clip counter and peak meter for a pair of 12-bit adc channels
// ----------------------------------------------------------------------------
// each slave transaction carries one sample pair; tlast marks the last pair of
// a block. per channel the unit counts samples at full scale high and low and
// tracks the largest positive value and negative magnitude over the first
// peak_window pairs of the block. the transaction with tlast produces one
// master transaction with the eight block values, then the block state clears.
// a pair is taken every cycle while s_tready is high: one transaction per cycle
// on the slave side, set by the single update of the per-channel accumulators.
// each result is registered in the output register or skid entry before it shows.
// when the receiver stalls, one result sits in the output register and a
// second in a skid entry; pairs keep flowing until the skid entry is full,
// then s_tready drops until m_tready frees it.
// reset clears all counts and peaks, empties the output side and sets
// peak_window to 1000. cfg_we writes peak_window; write it only while idle.
// counts saturate at MAX_BLOCK (and at 131071 in any case).
// ----------------------------------------------------------------------------
module dual_channel_clip_peak_meter_unit
    import dccpm_pkg::*;
#(
    parameter int MAX_BLOCK = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,    // peak_window
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,      // sample_a, sample_b
    input  logic                s_tlast,      // last_sample
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata       // clip_a_high, clip_a_low, clip_b_high,
                                              // clip_b_low, peak_a_up, peak_a_down,
                                              // peak_b_up, peak_b_down, zero fill
);

    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        (MAX_BLOCK < 131071) ? COUNT_W'(MAX_BLOCK) : COUNT_MAX17;

    logic [COUNT_W-1:0]  peak_window_reg;
    logic [COUNT_W-1:0]  pair_index_reg;
    logic                take;
    logic                track;
    logic                res_valid;
    logic [M_DATA_W-1:0] res_data;
    chan_stats_t         stats_a;
    chan_stats_t         stats_b;

    assign take  = s_tvalid && s_tready;
    assign track = pair_index_reg < peak_window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_window_reg <= WINDOW_RESET;
            pair_index_reg  <= '0;
        end else begin
            if (cfg_we) begin
                peak_window_reg <= cfg_wdata;
            end
            if (take) begin
                if (s_tlast) begin
                    pair_index_reg <= '0;
                end else if (pair_index_reg < COUNT_LIMIT) begin
                    pair_index_reg <= pair_index_reg + 1'b1;
                end
            end
        end
    end

    dccpm_chan_acc #(.COUNT_LIMIT(COUNT_LIMIT)) u_chan_a (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .last       (s_tlast),
        .track      (track),
        .sample     (s_tdata[11:0]),
        .stats_next (stats_a)
    );

    dccpm_chan_acc #(.COUNT_LIMIT(COUNT_LIMIT)) u_chan_b (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .last       (s_tlast),
        .track      (track),
        .sample     (s_tdata[23:12]),
        .stats_next (stats_b)
    );

    assign res_valid = take && s_tlast;
    assign res_data  = M_DATA_W'({stats_b.peak_down, stats_b.peak_up,
                                  stats_a.peak_down, stats_a.peak_up,
                                  stats_b.clip_low, stats_b.clip_high,
                                  stats_a.clip_low, stats_a.clip_high});

    dccpm_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res_data),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_ready (m_tready)
    );

    a_index_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && s_tlast |=> pair_index_reg == '0)
        else $error("pair index not cleared after block end");

    a_index_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        pair_index_reg <= COUNT_LIMIT)
        else $error("pair index above count limit");

    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output register");

    a_result_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        take && s_tlast |=> m_tvalid)
        else $error("block result not presented");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the dual channel clip and peak meter
// ----------------------------------------------------------------------------
// sample pairs go in on the slave stream with random gaps, block results come
// out on the master stream with random stalls. a local model of the meter
// tracks clip counts, peaks and pair index per block and queues the block
// result on each tlast pair. every master transaction is compared field by
// field with the oldest queued result. covers the reset window, empty and
// one-pair windows, a long receiver stall, blocks that run past the peak
// window and random blocks over several window settings.
// ----------------------------------------------------------------------------
module testbench;
    import dccpm_pkg::*;

    localparam int MAX_BLOCK_TB  = 65536;
    localparam int COUNT_LIMIT   = (MAX_BLOCK_TB < 131071) ? MAX_BLOCK_TB : 131071;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 130;
    localparam int LONG_LEN      = 72;

    typedef struct packed {
        chan_stats_t a;
        chan_stats_t b;
    } block_stats_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [COUNT_W-1:0]  cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    logic [COUNT_W-1:0] window_q   = WINDOW_RESET;
    int unsigned        pair_count = 0;
    block_stats_t       block_acc  = '0;
    block_stats_t       stats_due[$];

    int errors      = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    bit idle_en     = 1'b0;
    bit hold_req    = 1'b0;

    dual_channel_clip_peak_meter_unit #(
        .MAX_BLOCK(MAX_BLOCK_TB)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic chan_stats_t take_sample(chan_stats_t st,
                                                logic signed [SAMPLE_W-1:0] s, bit track);
        int v;
        v = s;
        if (v >= int'(CLIP_HIGH)) begin
            if (st.clip_high < COUNT_LIMIT) st.clip_high = st.clip_high + 1'b1;
        end else if (v <= int'(CLIP_LOW)) begin
            if (st.clip_low < COUNT_LIMIT) st.clip_low = st.clip_low + 1'b1;
        end
        if (track) begin
            if (v > 0 && v > int'(st.peak_up)) st.peak_up = v[UP_W-1:0];
            if (v < 0 && -v > int'(st.peak_down)) st.peak_down = 12'(-v);
        end
        return st;
    endfunction

    function automatic void meter_predict(logic signed [SAMPLE_W-1:0] a,
                                          logic signed [SAMPLE_W-1:0] b, logic last);
        bit track;
        track = pair_count < window_q;
        block_acc.a = take_sample(block_acc.a, a, track);
        block_acc.b = take_sample(block_acc.b, b, track);
        if (pair_count < COUNT_LIMIT) pair_count++;
        if (last) begin
            stats_due.push_back(block_acc);
            block_acc  = '0;
            pair_count = 0;
        end
    endfunction

    function automatic block_stats_t unpack_result(logic [M_DATA_W-1:0] d);
        block_stats_t r;
        r.a.clip_high = d[0 +: COUNT_W];
        r.a.clip_low  = d[COUNT_W +: COUNT_W];
        r.b.clip_high = d[2*COUNT_W +: COUNT_W];
        r.b.clip_low  = d[3*COUNT_W +: COUNT_W];
        r.a.peak_up   = d[4*COUNT_W +: UP_W];
        r.a.peak_down = d[4*COUNT_W+UP_W +: DOWN_W];
        r.b.peak_up   = d[4*COUNT_W+UP_W+DOWN_W +: UP_W];
        r.b.peak_down = d[4*COUNT_W+2*UP_W+DOWN_W +: DOWN_W];
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic check_result(input block_stats_t exp_r, input block_stats_t act_r);
        check_field("clip_a_high", exp_r.a.clip_high, act_r.a.clip_high);
        check_field("clip_a_low",  exp_r.a.clip_low,  act_r.a.clip_low);
        check_field("clip_b_high", exp_r.b.clip_high, act_r.b.clip_high);
        check_field("clip_b_low",  exp_r.b.clip_low,  act_r.b.clip_low);
        check_field("peak_a_up",   exp_r.a.peak_up,   act_r.a.peak_up);
        check_field("peak_a_down", exp_r.a.peak_down, act_r.a.peak_down);
        check_field("peak_b_up",   exp_r.b.peak_up,   act_r.b.peak_up);
        check_field("peak_b_down", exp_r.b.peak_down, act_r.b.peak_down);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (stats_due.size() == 0) begin
                $display("%0t: result transaction with no block pending, actual %h",
                         $time, m_tdata);
                errors++;
            end else begin
                check_result(stats_due.pop_front(), unpack_result(m_tdata));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, stats_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                stall_left = HOLD_CYCLES;
                hold_req   = 1'b0;
            end else if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 18);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_pair(input logic signed [SAMPLE_W-1:0] a,
                             input logic signed [SAMPLE_W-1:0] b, input logic last);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        meter_predict(a, b, last);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (stats_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_window(input logic [COUNT_W-1:0] w);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        window_q  = w;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        logic [SAMPLE_W-1:0] raw;
        raw = SAMPLE_W'($urandom());
        case ($urandom_range(0, 9))
            0: return CLIP_HIGH;
            1: return CLIP_LOW;
            2: return '0;
            3: return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
            default: return raw;
        endcase
    endfunction

    function automatic int random_block_len();
        int pick;
        int len;
        pick = $urandom_range(0, 9);
        if (pick < 7) return $urandom_range(1, 12);
        if (pick < 9) return $urandom_range(13, 60);
        if (window_q <= 64) begin
            len = int'(window_q) + int'($urandom_range(0, 3)) - 1;
            return (len < 1) ? 1 : len;
        end
        return $urandom_range(61, 120);
    endfunction

    task automatic send_random_block(input int len);
        for (int i = 0; i < len; i++) send_pair(random_sample(), random_sample(), i == len - 1);
    endtask

    // window left at its reset value
    task automatic test_reset_window();
        send_pair(CLIP_HIGH, CLIP_LOW, 1'b0);
        send_pair(CLIP_LOW, CLIP_HIGH, 1'b0);
        send_pair(12'sd0, 12'sd0, 1'b0);
        send_pair(12'sd1, -12'sd1, 1'b0);
        send_pair(-12'sd1, 12'sd1, 1'b0);
        send_pair(12'sd2046, -12'sd2047, 1'b1);
        send_pair(12'sd0, 12'sd0, 1'b1);
    endtask

    task automatic test_short_windows();
        write_window('0);
        send_pair(12'sd100, -12'sd100, 1'b0);
        send_pair(CLIP_HIGH, CLIP_LOW, 1'b1);
        write_window(17'd1);
        send_pair(12'sd5, -12'sd5, 1'b0);
        send_pair(CLIP_HIGH, CLIP_LOW, 1'b0);
        send_pair(CLIP_LOW, CLIP_HIGH, 1'b1);
    endtask

    // receiver holds off while one-pair blocks keep coming
    task automatic test_backpressure();
        wait_drained();
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_pair(random_sample(), random_sample(), 1'b1);
        wait_drained();
    endtask

    // a block longer than the window, whose peaks stop at the window edge, then a block inside a wide window
    task automatic test_long_blocks();
        idle_en = 1'b0;
        write_window(17'd64);
        for (int i = 0; i < LONG_LEN; i++) begin
            if (i < LONG_LEN - 8) send_pair(12'sd10, -12'sd10, 1'b0);
            else send_pair(CLIP_HIGH, CLIP_LOW, i == LONG_LEN - 1);
        end
        write_window(17'd65536);
        for (int i = 0; i < LONG_LEN; i++) begin
            if (i < LONG_LEN - 4) send_pair(CLIP_LOW, CLIP_HIGH, 1'b0);
            else send_pair(12'sd100, -12'sd7, i == LONG_LEN - 1);
        end
        idle_en = 1'b1;
    endtask

    task automatic test_random_blocks();
        logic [COUNT_W-1:0] windows[8];
        int                 start;
        windows = '{17'd0, 17'd1, 17'd5, 17'd32, WINDOW_RESET, 17'd65536, COUNT_MAX17,
                    17'($urandom_range(0, 131071))};
        foreach (windows[p]) begin
            if (p == 7) idle_en = 1'b0;
            write_window(windows[p]);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) send_random_block(random_block_len());
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        idle_en = 1'b1;

        test_reset_window();
        test_short_windows();
        test_backpressure();
        test_long_blocks();
        test_random_blocks();

        wait_drained();
        repeat (16) @(negedge aclk);
        if (errors == 0 && stats_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
